// ===== hw/rtl/rau_pkg.sv =====
// Shared constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  // Width of the external operand and result ports.
  localparam int IO_BITS = 64;
  // Width of the signed exponent port.
  localparam int EXP_BITS = 6;

  // Default configuration of the datapath.
  localparam int WORD_BITS_DEF    = 64;
  localparam int MAX_EXPONENT_DEF = 16;

  // Opcodes.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

endpackage
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: sequencer around a shared multiplier and divider.
//
// Input channel (in_*): opcode, two rationals with valid flags and an
// exponent. A transaction is taken when in_valid is high and in_stall low.
// Result channel (out_*): one reduced rational per input transaction, with
// a valid flag and an overflow flag, taken when out_valid is high and
// out_stall low.
// One transaction is in flight at a time; in_stall stays high from accept
// until its result has been taken. Early rejects post their result from idle.
// Each multiply runs on the serial multiplier, each division on the serial
// divider. A reduction runs the Euclid remainder steps on the divider and
// then divides numerator and denominator by the gcd. Add/sub use three
// multiplies, mul/div two, power two per exponent step plus one reduction
// per step and one more for a negative exponent. Run time grows with the
// exponent and the gcd chains, as the divider in the gcd loop yields one
// quotient bit per cycle.
// Synchronous reset returns the sequencer to idle and drops out_valid.
// While the receiver stalls, the result holds and no new input is taken.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_BITS    = rau_pkg::WORD_BITS_DEF,
  parameter int MAX_EXPONENT = rau_pkg::MAX_EXPONENT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        in_opcode,
  input  wire logic signed [rau_pkg::IO_BITS-1:0] in_lhs_num,
  input  wire logic signed [rau_pkg::IO_BITS-1:0] in_lhs_den,
  input  wire logic                              in_lhs_valid,
  input  wire logic signed [rau_pkg::IO_BITS-1:0] in_rhs_num,
  input  wire logic signed [rau_pkg::IO_BITS-1:0] in_rhs_den,
  input  wire logic                              in_rhs_valid,
  input  wire logic signed [rau_pkg::EXP_BITS-1:0] in_exponent,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [rau_pkg::IO_BITS-1:0]     out_res_num,
  output logic signed [rau_pkg::IO_BITS-1:0]     out_res_den,
  output logic                                   out_res_valid,
  output logic                                   out_overflow
);
  import rau_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINM = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE  = W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_GO, S_MUL_W, S_RED, S_GCD, S_GCD_W,
    S_DN_GO, S_DN_W, S_DD_GO, S_DD_W
  } state_t;

  state_t              state_r;
  logic [2:0]          op_r;
  logic [W-1:0]        ln_r, ld_r, rn_r, rd_r;
  logic                eneg_r;
  logic [EXP_BITS-1:0] cnt_r;
  logic [1:0]          mstep_r;
  logic                recip_r;
  logic [W-1:0]        rnum_r, rden_r, accn_r, accd_r;
  logic                neg_r;
  logic [W-1:0]        un_r, ud_r, ga_r, gb_r, nq_r;
  logic                ovf_r;
  logic                out_valid_r;
  logic [W-1:0]        res_num_r, res_den_r;
  logic                res_valid_r, res_ovf_r;

  // Input fields cut to the datapath width.
  logic [W-1:0]        i_ln, i_ld, i_rn, i_rd;
  logic [EXP_BITS-1:0] i_emag;
  logic                i_both, accept;

  // Shared unit hookup.
  logic         mul_start, mul_busy, mul_done, mul_ovf;
  logic [W-1:0] mul_a, mul_b, mul_prod;
  logic         div_start, div_busy, div_done;
  logic [W-1:0] div_a, div_b, div_quot, div_rem;

  logic         is_addsub, last_step, add_step;
  logic [W-1:0] sum_w;
  logic         add_ovf;
  logic [W-1:0] red_num;
  logic         red_ovf;

  assign i_ln   = in_lhs_num[W-1:0];
  assign i_ld   = in_lhs_den[W-1:0];
  assign i_rn   = in_rhs_num[W-1:0];
  assign i_rd   = in_rhs_den[W-1:0];
  assign i_emag = in_exponent[EXP_BITS-1] ? (~in_exponent + 1'b1) : in_exponent;
  assign i_both = in_lhs_valid && in_rhs_valid && (i_ld != '0) && (i_rd != '0);

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  // Multiply operand selection per opcode and step.
  assign is_addsub = (op_r == OP_ADD) || (op_r == OP_SUB);
  assign last_step = is_addsub ? (mstep_r == 2'd2) : (mstep_r == 2'd1);
  assign add_step  = is_addsub && (mstep_r == 2'd1);

  always_comb begin
    mul_a = ln_r;
    mul_b = rd_r;
    unique case (op_r)
      OP_ADD, OP_SUB: begin
        if (mstep_r == 2'd1) begin
          mul_a = rn_r;
          mul_b = ld_r;
        end else if (mstep_r == 2'd2) begin
          mul_a = ld_r;
          mul_b = rd_r;
        end
      end
      OP_MUL: begin
        mul_a = (mstep_r == 2'd0) ? ln_r : ld_r;
        mul_b = (mstep_r == 2'd0) ? rn_r : rd_r;
      end
      OP_DIV: begin
        mul_a = (mstep_r == 2'd0) ? ln_r : ld_r;
        mul_b = (mstep_r == 2'd0) ? rd_r : rn_r;
      end
      OP_POW: begin
        mul_a = (mstep_r == 2'd0) ? accn_r : accd_r;
        mul_b = (mstep_r == 2'd0) ? ln_r : ld_r;
      end
      default: begin
        mul_a = ln_r;
        mul_b = rd_r;
      end
    endcase
  end

  assign mul_start = (state_r == S_MUL_GO);

  // Cross-term sum or difference with signed overflow.
  assign sum_w   = (op_r == OP_SUB) ? (rnum_r - mul_prod) : (rnum_r + mul_prod);
  assign add_ovf = (op_r == OP_SUB)
                 ? ((rnum_r[W-1] != mul_prod[W-1]) && (sum_w[W-1] != rnum_r[W-1]))
                 : ((rnum_r[W-1] == mul_prod[W-1]) && (sum_w[W-1] != rnum_r[W-1]));

  // Divider operand selection for the gcd and the two final divisions.
  always_comb begin
    div_a = ga_r;
    div_b = gb_r;
    if (state_r == S_DN_GO) begin
      div_a = un_r;
      div_b = ga_r;
    end else if (state_r == S_DD_GO) begin
      div_a = ud_r;
      div_b = ga_r;
    end
  end

  assign div_start = ((state_r == S_GCD) && (gb_r != '0)) ||
                     (state_r == S_DN_GO) || (state_r == S_DD_GO);

  // Sign and range of the reduced terms.
  assign red_num = neg_r ? (~nq_r + 1'b1) : nq_r;
  assign red_ovf = (div_quot > MAXP) || (nq_r > (neg_r ? MINM : MAXP));

  rau_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod),
    .ovf   (mul_ovf)
  );

  rau_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_opcode;
            ln_r    <= i_ln;
            ld_r    <= i_ld;
            rn_r    <= i_rn;
            rd_r    <= i_rd;
            eneg_r  <= in_exponent[EXP_BITS-1];
            cnt_r   <= i_emag;
            mstep_r <= 2'd0;
            recip_r <= 1'b0;
            ovf_r   <= 1'b0;
            accn_r  <= ONE;
            accd_r  <= ONE;
            res_num_r   <= '0;
            res_den_r   <= ONE;
            res_valid_r <= 1'b0;
            res_ovf_r   <= 1'b0;
            priority case (in_opcode)
              OP_ADD, OP_SUB, OP_MUL: begin
                if (i_both) state_r <= S_MUL_GO;
                else out_valid_r <= 1'b1;
              end
              OP_DIV: begin
                if (i_both && (i_rn != '0)) state_r <= S_MUL_GO;
                else out_valid_r <= 1'b1;
              end
              OP_POW: begin
                if (!in_lhs_valid) begin
                  // Invalid base passes through untouched.
                  res_num_r   <= i_ln;
                  res_den_r   <= i_ld;
                  out_valid_r <= 1'b1;
                end else if ((i_ld == '0) || (int'(i_emag) > MAX_EXPONENT)) begin
                  out_valid_r <= 1'b1;
                end else if (i_emag == '0) begin
                  res_num_r   <= ONE;
                  res_valid_r <= 1'b1;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_MUL_GO;
                end
              end
              OP_NORM: begin
                rnum_r  <= i_ln;
                rden_r  <= i_ld;
                state_r <= S_RED;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_MUL_GO: begin
          state_r <= S_MUL_W;
        end
        S_MUL_W: begin
          if (mul_done) begin
            ovf_r <= ovf_r | mul_ovf | (add_step & add_ovf);
            if (mstep_r == 2'd0) rnum_r <= mul_prod;
            else if (add_step) rnum_r <= sum_w;
            if (last_step) begin
              rden_r  <= mul_prod;
              state_r <= S_RED;
            end else begin
              mstep_r <= mstep_r + 2'd1;
              state_r <= S_MUL_GO;
            end
          end
        end
        S_RED: begin
          if (rden_r == '0) begin
            res_num_r   <= '0;
            res_den_r   <= ONE;
            res_valid_r <= 1'b0;
            res_ovf_r   <= ovf_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            neg_r   <= rnum_r[W-1] ^ rden_r[W-1];
            un_r    <= rnum_r[W-1] ? (~rnum_r + 1'b1) : rnum_r;
            ud_r    <= rden_r[W-1] ? (~rden_r + 1'b1) : rden_r;
            ga_r    <= rnum_r[W-1] ? (~rnum_r + 1'b1) : rnum_r;
            gb_r    <= rden_r[W-1] ? (~rden_r + 1'b1) : rden_r;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (gb_r == '0) begin
            if (ga_r == '0) ga_r <= ONE;
            state_r <= S_DN_GO;
          end else begin
            state_r <= S_GCD_W;
          end
        end
        S_GCD_W: begin
          if (div_done) begin
            ga_r    <= gb_r;
            gb_r    <= div_rem;
            state_r <= S_GCD;
          end
        end
        S_DN_GO: begin
          state_r <= S_DN_W;
        end
        S_DN_W: begin
          if (div_done) begin
            nq_r    <= div_quot;
            state_r <= S_DD_GO;
          end
        end
        S_DD_GO: begin
          state_r <= S_DD_W;
        end
        S_DD_W: begin
          if (div_done) begin
            if ((op_r == OP_POW) && !recip_r) begin
              // One power step finished: fold into the accumulator.
              accn_r <= red_num;
              accd_r <= div_quot;
              ovf_r  <= ovf_r | red_ovf;
              cnt_r  <= cnt_r - 1'b1;
              if (cnt_r != EXP_BITS'(1)) begin
                mstep_r <= 2'd0;
                state_r <= S_MUL_GO;
              end else if (eneg_r) begin
                if (red_num == '0) begin
                  res_num_r   <= '0;
                  res_den_r   <= ONE;
                  res_valid_r <= 1'b0;
                  res_ovf_r   <= ovf_r | red_ovf;
                  out_valid_r <= 1'b1;
                  state_r     <= S_IDLE;
                end else begin
                  rnum_r  <= div_quot;
                  rden_r  <= red_num;
                  recip_r <= 1'b1;
                  state_r <= S_RED;
                end
              end else begin
                res_num_r   <= red_num;
                res_den_r   <= div_quot;
                res_valid_r <= 1'b1;
                res_ovf_r   <= ovf_r | red_ovf;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end else begin
              res_num_r   <= red_num;
              res_den_r   <= div_quot;
              res_valid_r <= 1'b1;
              res_ovf_r   <= ovf_r | red_ovf;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result terms are sign-extended to the port width.
  assign out_valid     = out_valid_r;
  assign out_res_num   = IO_BITS'(signed'(res_num_r));
  assign out_res_den   = IO_BITS'(signed'(res_den_r));
  assign out_res_valid = res_valid_r;
  assign out_overflow  = res_ovf_r;

  // An accepted transaction either starts work or posts its result at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE) || out_valid_r)
    else $error("accepted transaction neither started nor finished");

  // The multiplier is never restarted while it is still working.
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // The divider is never restarted mid-division nor given a zero divisor.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy && (div_b != '0))
    else $error("bad divider start");

  // A new transaction is never taken while a result is pending.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input accepted with result pending");

endmodule
`default_nettype wire

// ===== hw/rtl/rau_mul.sv =====
// Bit-serial signed multiplier with wrap detection.
`default_nettype none
module rau_mul #(
  parameter int W = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      prod,
  output logic              ovf
);
  import rau_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  ua_r;
  logic [W-1:0]  hi_r;
  logic [W-1:0]  lo_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    sum;
  logic [W-1:0]  lim;

  // One partial product per cycle, low multiplier bit first.
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ua_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r   <= a[W-1] ? (~a + 1'b1) : a;
        lo_r   <= b[W-1] ? (~b + 1'b1) : b;
        hi_r   <= '0;
        neg_r  <= a[W-1] ^ b[W-1];
        cnt_r  <= CW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= sum[W:1];
        lo_r  <= {sum[0], lo_r[W-1:1]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Largest magnitude that fits for the sign of the product.
  assign lim  = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign ovf  = (hi_r != '0) || (lo_r > lim);
  assign prod = neg_r ? (~lo_r + 1'b1) : lo_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rau_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rau_div #(
  parameter int W = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    sh;
  logic          ge;
  logic [W:0]    diff;

  // Shift in the next dividend bit and try the subtraction.
  assign sh   = {r_r, q_r[W-1]};
  assign ge   = sh >= {1'b0, d_r};
  assign diff = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= a;
        d_r    <= b;
        r_r    <= '0;
        cnt_r  <= CW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        r_r   <= ge ? diff[W-1:0] : sh[W-1:0];
        q_r   <= {q_r[W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r;
  assign rem  = r_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  // Opcodes left unused by the block.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic [63:0] POS_LIM = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
  localparam int EXP_LIMIT = MAX_EXPONENT_DEF;
  localparam int RANDOM_ITEMS = 680;
  localparam int IDLE_LIMIT = 1000000;
  localparam int HOLD_OFF_CYCLES = 3000;

  typedef struct {
    logic [2:0]         op;
    logic signed [63:0] ln, ld;
    logic               lv;
    logic signed [63:0] rn, rd;
    logic               rv;
    logic signed [5:0]  e;
  } req_t;

  typedef struct {
    logic signed [63:0] num, den;
    logic               ok, ovf;
  } rat_t;

  typedef struct {
    req_t req;
    bit   typed;
    rat_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_opcode;
  logic signed [63:0] in_lhs_num, in_lhs_den, in_rhs_num, in_rhs_den;
  logic in_lhs_valid, in_rhs_valid;
  logic signed [5:0] in_exponent;
  logic out_valid;
  logic out_stall;
  logic signed [63:0] out_res_num, out_res_den;
  logic out_res_valid, out_overflow;

  rat_t expected_q[$];
  int   fail_count;
  int   result_count;
  int   idle_cycles;
  bit   wrap_flag;

  rational_arithmetic_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_lhs_num   (in_lhs_num),
    .in_lhs_den   (in_lhs_den),
    .in_lhs_valid (in_lhs_valid),
    .in_rhs_num   (in_rhs_num),
    .in_rhs_den   (in_rhs_den),
    .in_rhs_valid (in_rhs_valid),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_res_valid(out_res_valid),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Rational arithmetic predictor with 64-bit wrapping.
  // ---------------------------------------------------------------------

  function automatic logic [63:0] magnitude(input logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Wrapping product; flags a product that does not fit.
  function automatic logic signed [63:0] mul_wrap(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic [63:0] ua, ub, lim;
    ua = magnitude(a);
    ub = magnitude(b);
    lim = (a[63] != b[63]) ? NEG_LIM : POS_LIM;
    if (ua != 0 && ub > lim / ua) wrap_flag = 1'b1;
    return a * b;
  endfunction

  // Wrapping sum or difference; flags a signed overflow.
  function automatic logic signed [63:0] add_wrap(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input bit sub);
    logic signed [63:0] s;
    s = sub ? a - b : a + b;
    if (sub ? (a[63] != b[63] && s[63] != a[63]) : (a[63] == b[63] && s[63] != a[63]))
      wrap_flag = 1'b1;
    return s;
  endfunction

  function automatic rat_t invalid_rat();
    rat_t r;
    r.num = 64'sd0;
    r.den = 64'sd1;
    r.ok = 1'b0;
    r.ovf = 1'b0;
    return r;
  endfunction

  // Euclid reduction with the sign moved into the numerator.
  function automatic rat_t reduce_rat(input logic signed [63:0] num,
                                      input logic signed [63:0] den);
    rat_t r;
    bit neg;
    logic [63:0] un, ud, a, b, t, n, d;
    if (den == 0) return invalid_rat();
    neg = num[63] != den[63];
    un = magnitude(num);
    ud = magnitude(den);
    a = un;
    b = ud;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    if (a == 0) a = 64'd1;
    n = un / a;
    d = ud / a;
    if (d > POS_LIM || n > (neg ? NEG_LIM : POS_LIM)) wrap_flag = 1'b1;
    r.num = neg ? (64'd0 - n) : n;
    r.den = d;
    r.ok = 1'b1;
    r.ovf = 1'b0;
    return r;
  endfunction

  // Integer power of the left operand, reduced after every exponent step.
  function automatic rat_t power_rat(input req_t q);
    rat_t acc;
    int ei, cnt;
    ei = int'(q.e);
    cnt = (ei < 0) ? -ei : ei;
    acc.num = 64'sd1;
    acc.den = 64'sd1;
    acc.ok = 1'b1;
    acc.ovf = 1'b0;
    if (!q.lv) begin
      acc.num = q.ln;
      acc.den = q.ld;
      acc.ok = 1'b0;
      return acc;
    end
    if (q.ld == 0 || cnt > EXP_LIMIT) return invalid_rat();
    while (cnt > 0) begin
      acc = reduce_rat(mul_wrap(acc.num, q.ln), mul_wrap(acc.den, q.ld));
      if (!acc.ok) return acc;
      cnt--;
    end
    if (ei < 0) begin
      if (acc.num == 0) return invalid_rat();
      acc = reduce_rat(acc.den, acc.num);
    end
    return acc;
  endfunction

  function automatic rat_t predict_result(input req_t q);
    rat_t r;
    bit both;
    logic signed [63:0] p1, p2, s, pd;
    both = q.lv && q.rv && q.ld != 0 && q.rd != 0;
    wrap_flag = 1'b0;
    case (q.op)
      OP_ADD, OP_SUB: begin
        if (!both) begin
          r = invalid_rat();
        end else begin
          p1 = mul_wrap(q.ln, q.rd);
          p2 = mul_wrap(q.rn, q.ld);
          s = add_wrap(p1, p2, q.op == OP_SUB);
          pd = mul_wrap(q.ld, q.rd);
          r = reduce_rat(s, pd);
        end
      end
      OP_MUL: begin
        if (both) begin
          p1 = mul_wrap(q.ln, q.rn);
          pd = mul_wrap(q.ld, q.rd);
          r = reduce_rat(p1, pd);
        end else begin
          r = invalid_rat();
        end
      end
      OP_DIV: begin
        if (both && q.rn != 0) begin
          p1 = mul_wrap(q.ln, q.rd);
          pd = mul_wrap(q.ld, q.rn);
          r = reduce_rat(p1, pd);
        end else begin
          r = invalid_rat();
        end
      end
      OP_POW:  r = power_rat(q);
      OP_NORM: r = reduce_rat(q.ln, q.ld);
      default: r = invalid_rat();
    endcase
    r.ovf = wrap_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: extremes, every opcode and the special cases.
  // ---------------------------------------------------------------------

  function automatic row_t mk(input logic [2:0] op,
                              input logic signed [63:0] ln, input logic signed [63:0] ld,
                              input logic lv,
                              input logic signed [63:0] rn, input logic signed [63:0] rd,
                              input logic rv, input logic signed [5:0] e, input bit typed,
                              input logic signed [63:0] xn, input logic signed [63:0] xd,
                              input logic xv, input logic xo);
    row_t w;
    w.req.op = op;
    w.req.ln = ln;
    w.req.ld = ld;
    w.req.lv = lv;
    w.req.rn = rn;
    w.req.rd = rd;
    w.req.rv = rv;
    w.req.e = e;
    w.typed = typed;
    w.want.num = xn;
    w.want.den = xd;
    w.want.ok = xv;
    w.want.ovf = xo;
    return w;
  endfunction

  row_t dir_tab[$];

  task automatic build_table();
    // Plain arithmetic on small operands.
    dir_tab.push_back(mk(OP_ADD, 1, 2, 1, 1, 3, 1, 0, 1, 5, 6, 1, 0));
    dir_tab.push_back(mk(OP_SUB, 1, 2, 1, 1, 3, 1, 0, 1, 1, 6, 1, 0));
    dir_tab.push_back(mk(OP_MUL, 2, 3, 1, 3, 4, 1, 0, 1, 1, 2, 1, 0));
    dir_tab.push_back(mk(OP_DIV, 1, 2, 1, 1, 4, 1, 0, 1, 2, 1, 1, 0));
    // Powers: positive, negative, zero, out of range, zero base, invalid base, extreme base.
    dir_tab.push_back(mk(OP_POW, 2, 3, 1, 0, 1, 1, 3, 1, 8, 27, 1, 0));
    dir_tab.push_back(mk(OP_POW, 2, 3, 1, 0, 1, 1, -2, 1, 9, 4, 1, 0));
    dir_tab.push_back(mk(OP_POW, 5, 7, 1, 0, 1, 1, 0, 1, 1, 1, 1, 0));
    dir_tab.push_back(mk(OP_POW, 1, 2, 1, 0, 1, 1, 16, 1, 1, 65536, 1, 0));
    dir_tab.push_back(mk(OP_POW, 1, 2, 1, 0, 1, 1, 17, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_POW, 1, 2, 1, 0, 1, 1, -32, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_POW, 1, 2, 1, 0, 1, 1, 31, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_POW, 0, 5, 1, 0, 1, 1, -1, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_POW, 7, 0, 0, 0, 1, 1, 3, 1, 7, 0, 0, 0));
    dir_tab.push_back(mk(OP_POW, S_MIN, 1, 1, 0, 1, 1, 2, 0, 0, 0, 0, 0));
    // Normalize: sign move, zero denominator, zero numerator, unreducible and equal extremes.
    dir_tab.push_back(mk(OP_NORM, 6, -4, 0, 0, 0, 0, 0, 1, -3, 2, 1, 0));
    dir_tab.push_back(mk(OP_NORM, 5, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_NORM, S_MIN, -1, 1, 0, 0, 0, 0, 1, S_MIN, 1, 1, 1));
    dir_tab.push_back(mk(OP_NORM, 0, -7, 1, 0, 0, 0, 0, 1, 0, 1, 1, 0));
    dir_tab.push_back(mk(OP_NORM, S_MIN, S_MIN, 1, 0, 0, 0, 0, 1, 1, 1, 1, 0));
    // Invalid operands, a zero denominator and a zero divisor.
    dir_tab.push_back(mk(OP_ADD, 1, 2, 0, 1, 3, 1, 0, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_SUB, 1, 2, 1, 1, 0, 1, 0, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_DIV, 1, 2, 1, 0, 3, 1, 0, 1, 0, 1, 0, 0));
    // A denominator product that wraps to zero, then wrapping products and sums.
    dir_tab.push_back(mk(OP_MUL, 1, 64'sh1_0000_0000, 1, 1, 64'sh1_0000_0000, 1, 0,
                         1, 0, 1, 0, 1));
    dir_tab.push_back(mk(OP_MUL, S_MAX, 1, 1, S_MAX, 1, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_ADD, S_MIN, 1, 1, S_MIN, -1, 1, 0, 0, 0, 0, 0, 0));
    // Unused opcodes.
    dir_tab.push_back(mk(OP_SPARE6, 1, 1, 1, 1, 1, 1, 0, 1, 0, 1, 0, 0));
    dir_tab.push_back(mk(OP_SPARE7, 1, 1, 1, 1, 1, 1, 0, 1, 0, 1, 0, 0));
  endtask

  // ---------------------------------------------------------------------
  // Random operands: mostly small terms so that the gcd loops stay short.
  // ---------------------------------------------------------------------

  function automatic logic signed [63:0] rand_term(input bit small_only);
    int unsigned k;
    logic [63:0] v;
    k = small_only ? $urandom_range(0, 69) : $urandom_range(0, 99);
    if (k < 70) v = {48'd0, 16'($urandom)};
    else if (k < 85) v = {32'd0, $urandom};
    else if (k < 95) v = {$urandom, $urandom};
    else begin
      case ($urandom_range(0, 4))
        0: v = S_MIN;
        1: v = S_MAX;
        2: v = 64'd0;
        3: v = 64'd1;
        default: v = '1;
      endcase
    end
    if (k < 95 && $urandom_range(0, 1) == 1) v = ~v + 64'd1;
    return v;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int unsigned k;
    bit small_base;
    k = $urandom_range(0, 99);
    q.op = (k < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) q.e = 6'($urandom);
    else q.e = 6'(int'($urandom_range(0, 12)) - 6);
    small_base = q.op == OP_POW && (q.e > 3 || q.e < -3);
    q.ln = rand_term(small_base);
    q.ld = rand_term(small_base);
    q.rn = rand_term(1'b0);
    q.rd = rand_term(1'b0);
    q.lv = $urandom_range(0, 19) != 0;
    q.rv = $urandom_range(0, 19) != 0;
    return q;
  endfunction

  // Idle length: mostly none or short, occasionally long.
  function automatic int rand_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Offers one transaction and waits until the block takes it.
  task automatic send_req(input req_t q, input bit typed, input rat_t want);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= q.op;
    in_lhs_num   <= q.ln;
    in_lhs_den   <= q.ld;
    in_lhs_valid <= q.lv;
    in_rhs_num   <= q.rn;
    in_rhs_den   <= q.rd;
    in_rhs_valid <= q.rv;
    in_exponent  <= q.e;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_q.push_back(typed ? want : predict_result(q));
  endtask

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------

  initial begin
    rat_t none;
    none = invalid_rat();
    fail_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ADD;
    in_lhs_num = '0;
    in_lhs_den = '0;
    in_lhs_valid = 1'b0;
    in_rhs_num = '0;
    in_rhs_den = '0;
    in_rhs_valid = 1'b0;
    in_exponent = '0;
    build_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    repeat (RANDOM_ITEMS) send_req(rand_req(), 1'b0, none);
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[rational_arithmetic_unit] OK");
    end else begin
      $display("[rational_arithmetic_unit] ERROR");
    end
    $finish;
  end

  // Receiver stall: random stretches, one long hold-off to back up the input.
  initial begin
    bit held;
    int span;
    held = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && result_count >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_stall <= 1'b0;
            repeat ($urandom_range(200, 2000)) @(posedge clk);
          end
          1: begin
            out_stall <= 1'b1;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 600)
                                               : $urandom_range(1, 5);
            repeat (span) @(posedge clk);
          end
          default: begin
            out_stall <= $urandom_range(0, 2) == 0;
          end
        endcase
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rat_t w;
    if (rst_n && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: num=%0d den=%0d", out_res_num, out_res_den);
        fail_count++;
      end else begin
        w = expected_q.pop_front();
        if (out_res_num !== w.num) begin
          $error("res_num: expected %0d, got %0d", w.num, out_res_num);
          fail_count++;
        end
        if (out_res_den !== w.den) begin
          $error("res_den: expected %0d, got %0d", w.den, out_res_den);
          fail_count++;
        end
        if (out_res_valid !== w.ok) begin
          $error("res_valid: expected %0b, got %0b", w.ok, out_res_valid);
          fail_count++;
        end
        if (out_overflow !== w.ovf) begin
          $error("overflow: expected %0b, got %0b", w.ovf, out_overflow);
          fail_count++;
        end
      end
    end
  end

  initial result_count = 0;

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[rational_arithmetic_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
